// ----- rtl/core/pvl_pkg.sv -----
package pvl_pkg;

   localparam int COORD_BITS = 12;
   localparam int IN_W       = 12;
   localparam int SIDES      = 6;
   localparam int CNT_W      = 4;
   localparam int OUT_W      = 16;

   // signed coordinate difference, two-term product, three-term product, numerator
   localparam int DIFF_W    = COORD_BITS + 1;
   localparam int MA_W      = 2 * DIFF_W;
   localparam int PROD_W    = MA_W + DIFF_W;
   localparam int NUM_W     = PROD_W + 1;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam int SAT_POS = (1 << (OUT_W - 1)) - 1;

   typedef struct packed {
      logic [COORD_BITS-1:0] x1;
      logic [COORD_BITS-1:0] y1;
      logic [COORD_BITS-1:0] x2;
      logic [COORD_BITS-1:0] y2;
   } line_type;

endpackage

// ----- rtl/core/pvl_if.sv -----
interface pvl_req_if import pvl_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [IN_W-1:0] start_x;
   logic [IN_W-1:0] start_y;
   logic [IN_W-1:0] end_x;
   logic [IN_W-1:0] end_y;

   modport source (output valid, output start_x, output start_y, output end_x,
                   output end_y, input ready);
   modport sink (input valid, input start_x, input start_y, input end_x,
                 input end_y, output ready);
endinterface

interface pvl_rsp_if import pvl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CNT_W-1:0]        corner_index;
   logic signed [OUT_W-1:0] point_x;
   logic signed [OUT_W-1:0] point_y;
   logic                    parallel_flag;
   logic                    clipped_flag;
   logic                    last_of_run;

   modport source (output valid, output corner_index, output point_x, output point_y,
                   output parallel_flag, output clipped_flag, output last_of_run,
                   input ready);
   modport sink (input valid, input corner_index, input point_x, input point_y,
                 input parallel_flag, input clipped_flag, input last_of_run,
                 output ready);
endinterface

// ----- rtl/core/pvl_div.sv -----
// Restoring divider on magnitudes, one quotient bit per cycle.
module pvl_div import pvl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [MA_W-1:0]  den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0]     num_ff;   // dividend shifts out, quotient shifts in
   logic [MA_W-1:0]      rem_ff;
   logic [MA_W-1:0]      den_ff;

   logic [MA_W:0] rem_shift;
   logic [MA_W:0] rem_diff;
   logic          qbit_in;

   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign qbit_in   = ~rem_diff[MA_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(NUM_W);
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= qbit_in ? rem_diff[MA_W-1:0] : rem_shift[MA_W-1:0];
            num_ff <= {num_ff[NUM_W-2:0], qbit_in};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

// ----- rtl/core/polygon_vertices_from_lines_top.sv -----
// Polygon corners from bounding lines. Each request transaction carries one line as two
// endpoints; SIDES lines close a polygon. The first line of a polygon yields no response,
// line i yields corner i (intersection with line i-1), and the last line yields its corner
// and then corner 0 (intersection with the first line, last_of_run set). Quotients are
// truncated toward zero and saturated to 16 bits; parallel lines give a zero point with
// parallel_flag. Each corner runs the shared 26x13 multiplier sequence, then two 40-bit
// bit-serial divisions, one for x and one for y; a parallel corner skips the divisions.
// A new line is accepted only once all corners of the previous one are computed; the
// last response may still be waiting.
module polygon_vertices_from_lines_top import pvl_pkg::*; (
   input logic       clock,
   input logic       reset,
   pvl_req_if.sink   req_ch,
   pvl_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_CHECK, ST_DIVX, ST_DIVY, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      MS_P1, MS_P2, MS_P3, MS_P4, MS_X0, MS_X1, MS_X2, MS_Y0, MS_Y1, MS_Y2, MS_DRAIN
   } mul_step_type;

   state_type    state_ff;
   mul_step_type mstep_ff;
   mul_step_type pstep_ff;
   mul_step_type mstep_in;

   logic [CNT_W-1:0] line_cnt_ff;
   line_type         first_ff;
   line_type         prev_ff;
   line_type         a_ff;
   line_type         b_ff;
   line_type         cur_line;
   logic [CNT_W-1:0] corner_ff;
   logic             last_ff;
   logic             closing_ff;

   logic signed [MA_W-1:0]   p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [MA_W-1:0]   d_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic [NUM_W-1:0]         prod_ext;
   logic [NUM_W-1:0]         accx_ff;
   logic [NUM_W-1:0]         accy_ff;

   logic [OUT_W-1:0] px_ff;
   logic [OUT_W-1:0] py_ff;
   logic             par_ff;
   logic             clip_ff;

   logic             rsp_vld_ff;
   logic [CNT_W-1:0] rsp_corner_ff;
   logic [OUT_W-1:0] rsp_x_ff;
   logic [OUT_W-1:0] rsp_y_ff;
   logic             rsp_par_ff;
   logic             rsp_clip_ff;
   logic             rsp_last_ff;

   logic signed [DIFF_W-1:0] dax, day, dbx, dby, ex, ey;
   logic signed [DIFF_W-1:0] ax1, ay1, bx1, by1;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [DIFF_W-1:0] mul_b;

   logic             div_start;
   logic             div_done;
   logic [NUM_W-1:0] div_num;
   logic [MA_W-1:0]  div_den;
   logic [NUM_W-1:0] div_quot;
   logic [NUM_W-1:0] absx;
   logic [NUM_W-1:0] absy;
   logic             neg_x;
   logic             neg_y;
   logic [OUT_W:0]   sat_x;
   logic [OUT_W:0]   sat_y;
   logic             req_acc;
   logic             out_free;

   // {clipped, value}: apply sign to the quotient magnitude and saturate
   function automatic logic [OUT_W:0] sat_q(input logic [NUM_W-1:0] q, input logic neg);
      logic [NUM_W-1:0] nq;
      logic [OUT_W:0]   r;
      nq = NUM_W'(0) - q;
      if (neg) begin
         if (q > NUM_W'(SAT_POS + 1)) r = {1'b1, 1'b1, {(OUT_W-1){1'b0}}};
         else                         r = {1'b0, nq[OUT_W-1:0]};
      end else begin
         if (q > NUM_W'(SAT_POS)) r = {1'b1, 1'b0, {(OUT_W-1){1'b1}}};
         else                     r = {1'b0, q[OUT_W-1:0]};
      end
      return r;
   endfunction

   assign cur_line = '{x1: req_ch.start_x[COORD_BITS-1:0], y1: req_ch.start_y[COORD_BITS-1:0],
                       x2: req_ch.end_x[COORD_BITS-1:0],   y2: req_ch.end_y[COORD_BITS-1:0]};

   assign ax1 = $signed({1'b0, a_ff.x1});
   assign ay1 = $signed({1'b0, a_ff.y1});
   assign bx1 = $signed({1'b0, b_ff.x1});
   assign by1 = $signed({1'b0, b_ff.y1});
   assign dax = $signed({1'b0, a_ff.x2}) - ax1;
   assign day = $signed({1'b0, a_ff.y2}) - ay1;
   assign dbx = $signed({1'b0, b_ff.x2}) - bx1;
   assign dby = $signed({1'b0, b_ff.y2}) - by1;
   assign ex  = bx1 - ax1;
   assign ey  = by1 - ay1;

   // one product per step; the product is registered in prod_ff before it is stored
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      mstep_in = MS_DRAIN;
      case (mstep_ff)
         MS_P1: begin mul_a = {{DIFF_W{day[DIFF_W-1]}}, day}; mul_b = dbx; mstep_in = MS_P2; end
         MS_P2: begin mul_a = {{DIFF_W{dby[DIFF_W-1]}}, dby}; mul_b = dax; mstep_in = MS_P3; end
         MS_P3: begin mul_a = {{DIFF_W{dax[DIFF_W-1]}}, dax}; mul_b = dbx; mstep_in = MS_P4; end
         MS_P4: begin mul_a = {{DIFF_W{day[DIFF_W-1]}}, day}; mul_b = dby; mstep_in = MS_X0; end
         MS_X0: begin mul_a = p3_ff; mul_b = ey;  mstep_in = MS_X1; end
         MS_X1: begin mul_a = p1_ff; mul_b = ax1; mstep_in = MS_X2; end
         MS_X2: begin mul_a = p2_ff; mul_b = bx1; mstep_in = MS_Y0; end
         MS_Y0: begin mul_a = p4_ff; mul_b = ex;  mstep_in = MS_Y1; end
         MS_Y1: begin mul_a = p2_ff; mul_b = ay1; mstep_in = MS_Y2; end
         MS_Y2: begin mul_a = p1_ff; mul_b = by1; mstep_in = MS_DRAIN; end
         default: begin mul_a = '0; mul_b = '0; mstep_in = MS_DRAIN; end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {prod_ff[PROD_W-1], prod_ff};

   assign absx    = accx_ff[NUM_W-1] ? NUM_W'(0) - accx_ff : accx_ff;
   assign absy    = accy_ff[NUM_W-1] ? NUM_W'(0) - accy_ff : accy_ff;
   assign div_den = d_ff[MA_W-1] ? MA_W'(0) - d_ff : d_ff;
   // y divides by -d
   assign neg_x   = accx_ff[NUM_W-1] ^ d_ff[MA_W-1];
   assign neg_y   = accy_ff[NUM_W-1] ^ ~d_ff[MA_W-1];
   assign sat_x   = sat_q(div_quot, neg_x);
   assign sat_y   = sat_q(div_quot, neg_y);

   assign div_start = (state_ff == ST_CHECK && d_ff != '0) || (state_ff == ST_DIVX && div_done);
   assign div_num   = (state_ff == ST_CHECK) ? absx : absy;

   pvl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_vld_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rsp_vld_ff  <= 1'b0;
         line_cnt_ff <= '0;
         closing_ff  <= 1'b0;
      end else begin
         // ST_OUT drives the response register itself
         if (rsp_vld_ff && rsp_ch.ready && state_ff != ST_OUT) rsp_vld_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  prev_ff <= cur_line;
                  b_ff    <= cur_line;
                  if (line_cnt_ff == '0) begin
                     first_ff    <= cur_line;
                     line_cnt_ff <= CNT_W'(1);
                  end else begin
                     a_ff      <= prev_ff;
                     corner_ff <= line_cnt_ff;
                     last_ff   <= 1'b0;
                     mstep_ff  <= MS_P1;
                     pstep_ff  <= MS_DRAIN;
                     state_ff  <= ST_MUL;
                     if (line_cnt_ff >= CNT_W'(SIDES - 1)) begin
                        closing_ff  <= 1'b1;
                        line_cnt_ff <= '0;
                     end else begin
                        closing_ff  <= 1'b0;
                        line_cnt_ff <= line_cnt_ff + 1'b1;
                     end
                  end
               end
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               pstep_ff <= mstep_ff;
               mstep_ff <= mstep_in;
               case (pstep_ff)
                  MS_P1: p1_ff <= prod_ff[MA_W-1:0];
                  MS_P2: p2_ff <= prod_ff[MA_W-1:0];
                  MS_P3: p3_ff <= prod_ff[MA_W-1:0];
                  MS_P4: p4_ff <= prod_ff[MA_W-1:0];
                  MS_X0: accx_ff <= prod_ext;
                  MS_X1: accx_ff <= accx_ff + prod_ext;
                  MS_X2: accx_ff <= accx_ff - prod_ext;
                  MS_Y0: accy_ff <= prod_ext;
                  MS_Y1: accy_ff <= accy_ff + prod_ext;
                  MS_Y2: accy_ff <= accy_ff - prod_ext;
                  default: ;
               endcase
               if (mstep_ff == MS_DRAIN) begin
                  d_ff     <= p1_ff - p2_ff;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               clip_ff <= 1'b0;
               if (d_ff == '0) begin
                  par_ff   <= 1'b1;
                  px_ff    <= '0;
                  py_ff    <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  par_ff   <= 1'b0;
                  state_ff <= ST_DIVX;
               end
            end
            ST_DIVX: begin
               if (div_done) begin
                  px_ff    <= sat_x[OUT_W-1:0];
                  clip_ff  <= sat_x[OUT_W];
                  state_ff <= ST_DIVY;
               end
            end
            ST_DIVY: begin
               if (div_done) begin
                  py_ff    <= sat_y[OUT_W-1:0];
                  clip_ff  <= clip_ff | sat_y[OUT_W];
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_vld_ff    <= 1'b1;
                  rsp_corner_ff <= corner_ff;
                  rsp_x_ff      <= px_ff;
                  rsp_y_ff      <= py_ff;
                  rsp_par_ff    <= par_ff;
                  rsp_clip_ff   <= clip_ff;
                  rsp_last_ff   <= last_ff;
                  if (closing_ff) begin
                     // closing corner: first line against the current one
                     a_ff       <= first_ff;
                     corner_ff  <= '0;
                     last_ff    <= 1'b1;
                     closing_ff <= 1'b0;
                     mstep_ff   <= MS_P1;
                     pstep_ff   <= MS_DRAIN;
                     state_ff   <= ST_MUL;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.corner_index  = rsp_corner_ff;
   assign rsp_ch.point_x       = rsp_x_ff;
   assign rsp_ch.point_y       = rsp_y_ff;
   assign rsp_ch.parallel_flag = rsp_par_ff;
   assign rsp_ch.clipped_flag  = rsp_clip_ff;
   assign rsp_ch.last_of_run   = rsp_last_ff;

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_last_ff |-> rsp_corner_ff == '0)
      else $error("closing transaction with nonzero corner index");

   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_par_ff |-> rsp_x_ff == '0 && rsp_y_ff == '0 && !rsp_clip_ff)
      else $error("parallel result carries a point or clip");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVX || state_ff == ST_DIVY)
      else $error("divider finished outside a division state");

   a_cnt_wrap: assert property (@(posedge clock) disable iff (reset)
      req_acc && line_cnt_ff == CNT_W'(SIDES - 1) |=> line_cnt_ff == '0)
      else $error("line counter did not wrap on the closing line");

endmodule
